// ===== hw/rtl/lfpid_pkg.sv =====
// Shared types and constants for the three-sensor line follower PID step.
`default_nettype none

package lfpid_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int GAIN_W     = 10;
	localparam int LIMIT_W    = 12;
	localparam int DRIVE_W    = 16;

	typedef logic signed [3:0]  err_t;
	typedef logic signed [12:0] sum_t;
	typedef logic [GAIN_W-1:0]  gain_t;
	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 2'd2;

	localparam gain_t  P_GAIN_RESET         = 10'd20;
	localparam gain_t  D_GAIN_RESET         = 10'd10;
	localparam limit_t INTEGRAL_LIMIT_RESET = 12'd0;

	// Steering errors produced by the sensor decode.
	localparam err_t ERR_LEFT_MID   = -4'sd1;
	localparam err_t ERR_MID_RIGHT  = 4'sd1;
	localparam err_t ERR_CENTER     = 4'sd0;
	localparam err_t ERR_RIGHT_ONLY = -4'sd2;
	localparam err_t ERR_LOST_LEFT  = 4'sd5;
	localparam err_t ERR_LEFT_ONLY  = 4'sd2;
	localparam err_t ERR_LOST_RIGHT = -4'sd5;

	typedef struct packed {
		gain_t  p_gain;
		gain_t  d_gain;
		limit_t integral_limit;
	} lfpid_cfg_t;

	typedef struct packed {
		logic prev_left;
		logic prev_right;
		err_t last_error;
		logic started;
		sum_t error_sum;
	} lfpid_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfpid_calc.sv =====
// Sensor decode, windup clamp and PID sum for one sample.
`default_nettype none

module lfpid_calc (
	input  wire logic                 left_on_tape,
	input  wire logic                 middle_on_tape,
	input  wire logic                 right_on_tape,
	input  wire lfpid_pkg::lfpid_cfg_t   cfg,
	input  wire lfpid_pkg::lfpid_state_t st,
	output lfpid_pkg::lfpid_state_t      st_next,
	output lfpid_pkg::drive_t            drive_change,
	output logic                         crossing
);
	import lfpid_pkg::*;

	err_t                err;
	logic signed [4:0]   diff;
	logic signed [15:0]  p_term;
	logic signed [15:0]  d_term;
	logic signed [13:0]  sum_raw;
	logic signed [13:0]  lim_pos;
	logic signed [13:0]  lim_neg;
	sum_t                sum_clamped;
	logic signed [16:0]  total;

	always_comb begin
		crossing = left_on_tape & middle_on_tape & right_on_tape;

		err = st.last_error;
		if (left_on_tape && middle_on_tape) begin
			err = ERR_LEFT_MID;
		end else if (middle_on_tape && right_on_tape) begin
			err = ERR_MID_RIGHT;
		end else if (middle_on_tape) begin
			err = ERR_CENTER;
		end else if (!left_on_tape && right_on_tape) begin
			err = ERR_RIGHT_ONLY;
		end else if (!left_on_tape && !right_on_tape && st.prev_left) begin
			err = ERR_LOST_LEFT;
		end else if (left_on_tape && !right_on_tape) begin
			err = ERR_LEFT_ONLY;
		end else if (!left_on_tape && !right_on_tape && st.prev_right) begin
			err = ERR_LOST_RIGHT;
		end

		diff = {err[3], err} - {st.last_error[3], st.last_error};

		p_term = $signed({6'b0, cfg.p_gain}) * $signed({{12{err[3]}}, err});
		// No derivative on the first sample or when the error is zero.
		if (st.started && (err != ERR_CENTER)) begin
			d_term = $signed({6'b0, cfg.d_gain}) * $signed({{11{diff[4]}}, diff});
		end else begin
			d_term = '0;
		end

		sum_raw = {st.error_sum[12], st.error_sum} + {{10{err[3]}}, err};
		lim_pos = $signed({2'b0, cfg.integral_limit});
		lim_neg = -lim_pos;
		if (sum_raw > lim_pos) begin
			sum_clamped = lim_pos[12:0];
		end else if (sum_raw < lim_neg) begin
			sum_clamped = lim_neg[12:0];
		end else begin
			sum_clamped = sum_raw[12:0];
		end

		total = {p_term[15], p_term} + {d_term[15], d_term}
			+ {{4{sum_clamped[12]}}, sum_clamped};

		if (crossing) begin
			st_next      = st;
			drive_change = '0;
		end else begin
			st_next.prev_left  = left_on_tape;
			st_next.prev_right = right_on_tape;
			st_next.last_error = err;
			st_next.started    = 1'b1;
			st_next.error_sum  = sum_clamped;
			drive_change       = total[15:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/line_follower_pid_step_core.sv =====
// Path: an accepted sample is held in the input stage register and moves to the
// result register, which drives m_axis_tvalid, once that register is free or taken.
// Throughput: one sample per cycle unless m_axis_tready holds a result back.
// Decode, both gain multiplies and the clamped sum sit between the two registers.
// Reset (arst_n low, asynchronous) empties both stages, clears the PID state
// and loads p_gain 20, d_gain 10 and integral_limit 0.
// Top level of the three-sensor line follower PID step.
`default_nettype none

module line_follower_pid_step_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Sample stream. tdata: [0] left_on_tape, [1] middle_on_tape,
	// [2] right_on_tape, [7:3] zero.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	// Result stream. tdata: [15:0] drive_change. tuser: [0] crossing.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,
	output logic             m_axis_tuser,
	// Register writes.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lfpid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lfpid_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lfpid_pkg::*;

	lfpid_cfg_t   cfg_q;
	lfpid_state_t state_q;
	lfpid_state_t state_next;

	logic         valid_s1;
	logic [2:0]   sens_s1;
	logic         advance;

	drive_t       drive_next;
	logic         crossing_next;
	drive_t       drive_q;
	logic         crossing_q;
	logic         out_valid_q;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain         <= P_GAIN_RESET;
			cfg_q.d_gain         <= D_GAIN_RESET;
			cfg_q.integral_limit <= INTEGRAL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_P_GAIN:         cfg_q.p_gain         <= cfg_data[GAIN_W-1:0];
				CFG_D_GAIN:         cfg_q.d_gain         <= cfg_data[GAIN_W-1:0];
				CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[LIMIT_W-1:0];
				default:            ;
			endcase
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sens_s1 <= s_axis_tdata[2:0];
		end
	end

	lfpid_calc u_calc (
		.left_on_tape   (sens_s1[0]),
		.middle_on_tape (sens_s1[1]),
		.right_on_tape  (sens_s1[2]),
		.cfg            (cfg_q),
		.st             (state_q),
		.st_next        (state_next),
		.drive_change   (drive_next),
		.crossing       (crossing_next)
	);

	// The PID state moves on when a sample leaves the input stage, so the next
	// sample in line already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_next;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q    <= drive_next;
			crossing_q <= crossing_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;
	assign m_axis_tuser  = crossing_q;

endmodule

`default_nettype wire

// ===== bench/pid_step_score_pkg.sv =====
// Steering predictor and result scoreboard for the line follower PID step bench.
package pid_step_score_pkg;

	import lfpid_pkg::*;

	typedef struct packed {
		drive_t drive;
		logic   crossing;
	} steer_result_t;

	class pid_step_scoreboard;
		gain_t  p_gain;
		gain_t  d_gain;
		limit_t integral_limit;

		logic prev_left;
		logic prev_right;
		int   last_error;
		bit   started;
		int   error_sum;

		steer_result_t expected_steer[$];
		int            fail_count;

		function new();
			p_gain         = P_GAIN_RESET;
			d_gain         = D_GAIN_RESET;
			integral_limit = INTEGRAL_LIMIT_RESET;
			prev_left      = 1'b0;
			prev_right     = 1'b0;
			last_error     = 0;
			started        = 1'b0;
			error_sum      = 0;
			fail_count     = 0;
		endfunction

		function void write_register(input logic [CFG_IDX_W-1:0] index,
				input logic [CFG_DATA_W-1:0] value);
			case (index)
			CFG_P_GAIN: begin
				p_gain = value[GAIN_W-1:0];
			end
			CFG_D_GAIN: begin
				d_gain = value[GAIN_W-1:0];
			end
			CFG_INTEGRAL_LIMIT: begin
				integral_limit = value[LIMIT_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		// Works out the steering result of one accepted sample.
		function void note_sample(input logic left, input logic middle, input logic right);
			steer_result_t outcome;
			int err;
			int slope;
			int bound;
			int total;
			int p_val;
			int d_val;

			outcome.crossing = 1'b0;
			if (left && middle && right) begin
				// A crossing leaves the whole PID state as it was.
				outcome.drive    = '0;
				outcome.crossing = 1'b1;
				expected_steer.push_back(outcome);
				return;
			end

			err = last_error;
			if (left && middle)
				err = ERR_LEFT_MID;
			else if (middle && right)
				err = ERR_MID_RIGHT;
			else if (middle)
				err = ERR_CENTER;
			else if (!left && right)
				err = ERR_RIGHT_ONLY;
			else if (!left && !right && prev_left)
				err = ERR_LOST_LEFT;
			else if (left && !right)
				err = ERR_LEFT_ONLY;
			else if (!left && !right && prev_right)
				err = ERR_LOST_RIGHT;

			p_val = p_gain;
			d_val = d_gain;
			slope = 0;
			if (started && err != 0)
				slope = d_val * (err - last_error);
			else
				started = 1'b1;

			bound = integral_limit;
			error_sum += err;
			if (error_sum > bound)
				error_sum = bound;
			else if (error_sum < -bound)
				error_sum = -bound;

			total = p_val * err + slope + error_sum;
			prev_left  = left;
			prev_right = right;
			last_error = err;

			outcome.drive = total[DRIVE_W-1:0];
			expected_steer.push_back(outcome);
		endfunction

		function void check_result(input logic [DRIVE_W-1:0] drive_bits, input logic crossing);
			steer_result_t want;
			drive_t got_drive;

			got_drive = drive_bits;
			if (expected_steer.size() == 0) begin
				$error("result transfer with no sample awaiting it: drive_change %0d crossing %0d",
					got_drive, crossing);
				fail_count++;
				return;
			end
			want = expected_steer.pop_front();
			if (got_drive !== want.drive) begin
				$error("drive_change mismatch: expected %0d, actual %0d", want.drive, got_drive);
				fail_count++;
			end
			if (crossing !== want.crossing) begin
				$error("crossing mismatch: expected %0d, actual %0d", want.crossing, crossing);
				fail_count++;
			end
		endfunction
	endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level bench for line_follower_pid_step_core: drives samples and register writes.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import lfpid_pkg::*;
	import pid_step_score_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	// Bit 0 left, bit 1 middle, bit 2 right.
	localparam logic [2:0] DIRECTED_SENSORS [21] = '{
		3'b000, 3'b111, 3'b001, 3'b000, 3'b000, 3'b011, 3'b110,
		3'b010, 3'b100, 3'b000, 3'b000, 3'b000, 3'b000, 3'b101,
		3'b111, 3'b001, 3'b001, 3'b001, 3'b001, 3'b111, 3'b010
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [15:0]           m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pid_step_scoreboard board;
	int src_idle_pct;
	int sink_idle_pct;
	int cycle_count = 0;

	line_follower_pid_step_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("line_follower_pid_step_core verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Every transfer on the three channels is seen here, before the edge takes effect.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_register(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				board.note_sample(s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2]);
			if (m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic set_gains(input int p_val, input int d_val, input int limit_val);
		write_reg(CFG_P_GAIN, CFG_DATA_W'(p_val));
		write_reg(CFG_D_GAIN, CFG_DATA_W'(d_val));
		write_reg(CFG_INTEGRAL_LIMIT, CFG_DATA_W'(limit_val));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [2:0] sensors);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, sensors};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Holds the sender back until every predicted result has been checked.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.expected_steer.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Runs of one sensor pattern drive the integral into its clamps and reach the
	// lost-line rows, which need a blank sample after an outer sensor saw tape.
	task automatic random_samples(input int count);
		int sent;
		int run_len;
		logic [2:0] pattern;

		sent = 0;
		while (sent < count) begin
			pattern = 3'($urandom_range(0, 7));
			run_len = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 40) : 1;
			repeat (run_len) begin
				send_sample(pattern);
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int p_val, input int d_val, input int limit_val,
			input int src_pct, input int sink_pct, input int count);
		set_gains(p_val, d_val, limit_val);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		random_samples(count);
		wait_idle();
	endtask

	initial begin
		board         = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_P_GAIN;
		cfg_data      = '0;
		src_idle_pct  = 29;
		sink_idle_pct = 87;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A small integral bound lets the short directed run reach both clamps.
		set_gains(P_GAIN_RESET, D_GAIN_RESET, 6);
		foreach (DIRECTED_SENSORS[i])
			send_sample(DIRECTED_SENSORS[i]);
		wait_idle();

		run_phase(1023, 1023, 4095, 29, 87, 240);
		run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 40),
			29, 87, 240);
		run_phase(0, 0, 0, 87, 29, 240);
		run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 4095),
			87, 29, 240);
		run_phase(1023, 0, 1, 0, 0, 240);

		if (board.fail_count == 0) begin
			$display("line_follower_pid_step_core verification clean");
		end else begin
			$display("line_follower_pid_step_core verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lfpid_pkg.sv
hw/rtl/lfpid_calc.sv
hw/rtl/line_follower_pid_step_core.sv
bench/pid_step_score_pkg.sv
bench/testbench.sv
